// ----- design/bsn_pkg.sv -----
// Shared types and constants for the B-spline stencil node query block.
// Used by bsn_front, bsn_fifo, bsn_back and bspline_stencil_node_query.
package bsn_pkg;

    localparam int COORD_W    = 32;
    localparam int SIZE_W     = 11;
    localparam int NODE_W     = 12;
    localparam int POS_W      = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int NUM_AXES   = 3;
    localparam int QDEPTH     = 2;
    localparam int MAX_DIM_DEF = 1024;

    localparam logic [POS_W-1:0] STENCIL_LAST = 6'd63;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z   = 3'd6;

    localparam logic [COORD_W-1:0] INV_CELL_RST = 32'd65536;
    localparam logic [SIZE_W-1:0]  SIZE_RST     = 11'd1024;

    typedef struct packed {
        logic [COORD_W-1:0] origin_x;
        logic [COORD_W-1:0] origin_y;
        logic [COORD_W-1:0] origin_z;
        logic [COORD_W-1:0] inv_cell_size;
    } t_geom_cfg;

    typedef struct packed {
        logic [SIZE_W-1:0] size_x;
        logic [SIZE_W-1:0] size_y;
        logic [SIZE_W-1:0] size_z;
    } t_size_cfg;

endpackage

// ----- design/bsn_front.sv -----
// Front end: takes query points and computes the saturated base cell per axis.
// Four-stage elastic pipeline; depends on bsn_pkg.
module bsn_front #(
    parameter int MAX_DIM = bsn_pkg::MAX_DIM_DEF,
    parameter int BW      = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    output logic                         o_full,
    input  logic [bsn_pkg::COORD_W-1:0]  i_point_x,
    input  logic [bsn_pkg::COORD_W-1:0]  i_point_y,
    input  logic [bsn_pkg::COORD_W-1:0]  i_point_z,
    input  bsn_pkg::t_geom_cfg           i_cfg,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [3*BW-1:0]              o_base
);
    import bsn_pkg::*;

    localparam logic signed [33:0] MAXQ = 34'(MAX_DIM);
    localparam logic signed [33:0] MINQ = -34'sd4;

    logic [3:0]              r_v;
    logic [3:0]              n_v;
    logic [3:0]              w_rdy;
    logic [COORD_W-1:0]      w_pt [NUM_AXES];
    logic [COORD_W-1:0]      w_org [NUM_AXES];
    logic [COORD_W-1:0]      r_pt [NUM_AXES];
    logic                    r_neg [NUM_AXES];
    logic                    r_neg2 [NUM_AXES];
    logic [COORD_W-1:0]      r_mag [NUM_AXES];
    logic [2*COORD_W-1:0]    r_prod [NUM_AXES];
    logic signed [BW-1:0]    r_base [NUM_AXES];
    logic signed [32:0]      w_rel [NUM_AXES];
    logic [32:0]             w_nrel [NUM_AXES];
    logic signed [33:0]      w_qm1 [NUM_AXES];
    logic signed [BW-1:0]    w_clamp [NUM_AXES];

    assign w_pt[0]  = i_point_x;
    assign w_pt[1]  = i_point_y;
    assign w_pt[2]  = i_point_z;
    assign w_org[0] = i_cfg.origin_x;
    assign w_org[1] = i_cfg.origin_y;
    assign w_org[2] = i_cfg.origin_z;

    // A stage can take new data when it is empty or its content moves on.
    assign w_rdy[3] = !r_v[3] || i_ready;
    assign w_rdy[2] = !r_v[2] || w_rdy[3];
    assign w_rdy[1] = !r_v[1] || w_rdy[2];
    assign w_rdy[0] = !r_v[0] || w_rdy[1];
    assign o_full   = !w_rdy[0];
    assign o_valid  = r_v[3];

    always_comb begin
        n_v[0] = w_rdy[0] ? i_push : r_v[0];
        n_v[1] = w_rdy[1] ? r_v[0] : r_v[1];
        n_v[2] = w_rdy[2] ? r_v[1] : r_v[2];
        n_v[3] = w_rdy[3] ? r_v[2] : r_v[3];
    end

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            w_rel[a]  = {r_pt[a][COORD_W-1], r_pt[a]} - {w_org[a][COORD_W-1], w_org[a]};
            w_nrel[a] = -w_rel[a];
            // Floor of the Q32.32 product, less one. For a negative offset the
            // floor is -(hi + frac_nonzero), and minus one of that is its complement.
            if (r_neg2[a]) begin
                w_qm1[a] = ~{2'b00, r_prod[a][63:32]} - {33'd0, |r_prod[a][31:0]};
            end else begin
                w_qm1[a] = {2'b00, r_prod[a][63:32]} - 34'sd1;
            end
            if (w_qm1[a] < MINQ) begin
                w_clamp[a] = BW'(MINQ);
            end else if (w_qm1[a] > MAXQ) begin
                w_clamp[a] = BW'(MAXQ);
            end else begin
                w_clamp[a] = BW'(w_qm1[a]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < NUM_AXES; a++) begin
            if (w_rdy[0]) begin
                r_pt[a] <= w_pt[a];
            end
            if (w_rdy[1]) begin
                r_neg[a] <= w_rel[a][32];
                r_mag[a] <= w_rel[a][32] ? w_nrel[a][31:0] : w_rel[a][31:0];
            end
            if (w_rdy[2]) begin
                r_neg2[a] <= r_neg[a];
                r_prod[a] <= r_mag[a] * i_cfg.inv_cell_size;
            end
            if (w_rdy[3]) begin
                r_base[a] <= w_clamp[a];
            end
        end
    end

    assign o_base = {r_base[2], r_base[1], r_base[0]};

endmodule

// ----- design/bsn_fifo.sv -----
// Short queue of base-cell triples between the front and back ends.
// Register-based; depth from bsn_pkg.
module bsn_fifo #(
    parameter int W = 36
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    output logic         o_valid,
    input  logic         i_pop,
    output logic [W-1:0] o_data
);
    import bsn_pkg::*;

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    logic [W-1:0]  r_mem [QDEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_full  = (r_cnt == CW'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PW'(QDEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == PW'(QDEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ----- design/bsn_back.sv -----
// Back end: walks the 64 stencil nodes of one base cell into a single output
// register, one node per cycle while that register is empty or popped. Depends on bsn_pkg.
module bsn_back #(
    parameter int BW = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_take,
    input  logic [3*BW-1:0]             i_base,
    input  bsn_pkg::t_size_cfg          i_size,
    output logic                        o_empty,
    input  logic                        i_pop,
    output logic [bsn_pkg::NODE_W-1:0]  o_node_x,
    output logic [bsn_pkg::NODE_W-1:0]  o_node_y,
    output logic [bsn_pkg::NODE_W-1:0]  o_node_z,
    output logic [bsn_pkg::POS_W-1:0]   o_stencil_pos,
    output logic                        o_inside_res,
    output logic                        o_last
);
    import bsn_pkg::*;

    localparam int EW = (BW > NODE_W) ? BW : NODE_W;

    logic                  r_busy;
    logic [POS_W-1:0]      r_cnt;
    logic signed [BW-1:0]  r_base [NUM_AXES];
    logic                  r_out_v;
    logic [NODE_W-1:0]     r_node [NUM_AXES];
    logic [POS_W-1:0]      r_pos;
    logic                  r_inside;
    logic                  r_last;
    logic                  w_step;
    logic                  w_done;
    logic signed [BW-1:0]  w_off [NUM_AXES];
    logic signed [BW-1:0]  w_node [NUM_AXES];
    logic signed [EW-1:0]  w_ext [NUM_AXES];
    logic [SIZE_W-1:0]     w_size [NUM_AXES];
    logic [NUM_AXES-1:0]   w_in;

    assign w_step = r_busy && (!r_out_v || i_pop);
    assign w_done = w_step && (r_cnt == STENCIL_LAST);
    // The next base cell is loaded on the cycle the last node goes out.
    assign o_take = i_valid && (!r_busy || w_done);

    assign w_off[0] = BW'(r_cnt[5:4]);
    assign w_off[1] = BW'(r_cnt[3:2]);
    assign w_off[2] = BW'(r_cnt[1:0]);
    assign w_size[0] = i_size.size_x;
    assign w_size[1] = i_size.size_y;
    assign w_size[2] = i_size.size_z;

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            w_node[a] = r_base[a] + w_off[a];
            w_ext[a]  = EW'(w_node[a]);
            w_in[a]   = !w_node[a][BW-1] && ($unsigned(w_ext[a]) < EW'(w_size[a]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_cnt   <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (o_take) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end else if (w_step) begin
                r_cnt <= r_cnt + POS_W'(1);
            end
            if (w_step) begin
                r_out_v <= 1'b1;
            end else if (i_pop) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < NUM_AXES; a++) begin
            if (o_take) begin
                r_base[a] <= i_base[a*BW +: BW];
            end
            if (w_step) begin
                r_node[a] <= w_ext[a][NODE_W-1:0];
            end
        end
        if (w_step) begin
            r_pos    <= r_cnt;
            r_inside <= &w_in;
            r_last   <= (r_cnt == STENCIL_LAST);
        end
    end

    assign o_empty       = !r_out_v;
    assign o_node_x      = r_node[0];
    assign o_node_y      = r_node[1];
    assign o_node_z      = r_node[2];
    assign o_stencil_pos = r_pos;
    assign o_inside_res  = r_inside;
    assign o_last        = r_last;

endmodule

// ----- design/bspline_stencil_node_query.sv -----
// Top level of the cubic B-spline stencil node query block.
// Instantiates bsn_front, bsn_fifo and bsn_back; depends on bsn_pkg.
//
// Each query point accepted on the push side yields 64 stencil nodes on the
// pop side, in i, j, k order with k innermost, the last one flagged by o_last.
// The base cell per axis is floor((p - origin) * inv_cell_size) - 1, clamped
// to [-4, MAX_DIM]; o_inside_res marks nodes with 0 <= index < size on every
// axis, and node indices are 12-bit two's complement. Results leave at one
// node per cycle while i_pop is held, so the output port sets the pace. The
// first node of a point passes through four front-end stages, the queue, the
// back-end base register and the output register before it reaches the pop
// side. The front end and a two-entry queue keep taking points while the back
// end is still walking an earlier stencil. Configuration writes are always
// ready and must only be issued while the block is idle.
module bspline_stencil_node_query #(
    parameter int MAX_DIM = bsn_pkg::MAX_DIM_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic [bsn_pkg::COORD_W-1:0]   i_point_x,
    input  logic [bsn_pkg::COORD_W-1:0]   i_point_y,
    input  logic [bsn_pkg::COORD_W-1:0]   i_point_z,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic [bsn_pkg::NODE_W-1:0]    o_node_x,
    output logic [bsn_pkg::NODE_W-1:0]    o_node_y,
    output logic [bsn_pkg::NODE_W-1:0]    o_node_z,
    output logic [bsn_pkg::POS_W-1:0]     o_stencil_pos,
    output logic                          o_inside_res,
    output logic                          o_last,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bsn_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bsn_pkg::COORD_W-1:0]   i_cfg_data
);
    import bsn_pkg::*;

    localparam int BW = $clog2(MAX_DIM + 4) + 1;

    t_geom_cfg         r_geom;
    t_size_cfg         r_size;
    logic              w_f_valid;
    logic              w_q_full;
    logic              w_q_valid;
    logic              w_take;
    logic [3*BW-1:0]   w_f_base;
    logic [3*BW-1:0]   w_q_base;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom.origin_x      <= '0;
            r_geom.origin_y      <= '0;
            r_geom.origin_z      <= '0;
            r_geom.inv_cell_size <= INV_CELL_RST;
            r_size.size_x        <= SIZE_RST;
            r_size.size_y        <= SIZE_RST;
            r_size.size_z        <= SIZE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ORIGIN_X: r_geom.origin_x      <= i_cfg_data;
                CFG_ORIGIN_Y: r_geom.origin_y      <= i_cfg_data;
                CFG_ORIGIN_Z: r_geom.origin_z      <= i_cfg_data;
                CFG_INV_CELL: r_geom.inv_cell_size <= i_cfg_data;
                CFG_SIZE_X:   r_size.size_x        <= i_cfg_data[SIZE_W-1:0];
                CFG_SIZE_Y:   r_size.size_y        <= i_cfg_data[SIZE_W-1:0];
                CFG_SIZE_Z:   r_size.size_z        <= i_cfg_data[SIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    bsn_front #(
        .MAX_DIM (MAX_DIM),
        .BW      (BW)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (i_push),
        .o_full    (o_full),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .i_point_z (i_point_z),
        .i_cfg     (r_geom),
        .o_valid   (w_f_valid),
        .i_ready   (!w_q_full),
        .o_base    (w_f_base)
    );

    bsn_fifo #(
        .W (3*BW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_valid),
        .i_data  (w_f_base),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .i_pop   (w_take),
        .o_data  (w_q_base)
    );

    bsn_back #(
        .BW (BW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_q_valid),
        .o_take        (w_take),
        .i_base        (w_q_base),
        .i_size        (r_size),
        .o_empty       (o_empty),
        .i_pop         (i_pop),
        .o_node_x      (o_node_x),
        .o_node_y      (o_node_y),
        .o_node_z      (o_node_z),
        .o_stencil_pos (o_stencil_pos),
        .o_inside_res  (o_inside_res),
        .o_last        (o_last)
    );

`ifndef SYNTH
    // The end-of-stencil flag marks exactly the final node position.
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_last == (o_stencil_pos == STENCIL_LAST)))
        else $error("last flag does not match stencil position");

    // Nodes of one stencil come out in consecutive positions.
    a_pos_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && i_pop && !o_last) |=>
            (o_empty || o_stencil_pos == $past(o_stencil_pos) + 6'd1))
        else $error("stencil position skipped or repeated");

    // Within a row along z, the z index steps by one.
    a_z_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && i_pop && o_stencil_pos[1:0] != 2'd3) |=>
            (o_empty || o_node_z == $past(o_node_z) + 12'd1))
        else $error("z node index did not advance by one");

    // A full queue that is not popped stays full, so no entry is lost while stalled.
    a_q_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_full && !w_take) |=> w_q_full)
        else $error("queue lost an entry while stalled");
`endif

endmodule

// ----- dv/tb.sv -----
// Testbench for bspline_stencil_node_query: pushes query points, writes the grid registers
// between phases, predicts all 64 stencil nodes of each point and checks every popped word.
// Depends on bsn_pkg and the design sources only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bsn_pkg::*;

    localparam int MAX_DIM      = MAX_DIM_DEF;
    localparam int RAND_PHASES  = 5;
    localparam int PHASE_POINTS = 20;
    localparam int LONG_HOLD    = 600;
    localparam int TAIL_CYCLES  = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam logic [CFG_IDX_W-1:0] ORIGIN_REG [NUM_AXES] =
        '{CFG_ORIGIN_X, CFG_ORIGIN_Y, CFG_ORIGIN_Z};
    localparam logic [CFG_IDX_W-1:0] SIZE_REG [NUM_AXES] =
        '{CFG_SIZE_X, CFG_SIZE_Y, CFG_SIZE_Z};

    typedef struct packed {
        logic [NODE_W-1:0] node_x;
        logic [NODE_W-1:0] node_y;
        logic [NODE_W-1:0] node_z;
        logic [POS_W-1:0]  pos;
        logic              in_grid;
        logic              last;
    } t_stencil_node;

    typedef enum logic {ROW_POINT, ROW_REG} t_row_kind;

    // For a register row, px carries the write data.
    typedef struct {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [COORD_W-1:0]   px;
        logic [COORD_W-1:0]   py;
        logic [COORD_W-1:0]   pz;
        bit                   known;
        int                   bx;
        int                   by;
        int                   bz;
    } t_stim_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_push;
    logic                 o_full;
    logic [COORD_W-1:0]   i_point_x;
    logic [COORD_W-1:0]   i_point_y;
    logic [COORD_W-1:0]   i_point_z;
    logic                 o_empty;
    logic                 i_pop;
    logic [NODE_W-1:0]    o_node_x;
    logic [NODE_W-1:0]    o_node_y;
    logic [NODE_W-1:0]    o_node_z;
    logic [POS_W-1:0]     o_stencil_pos;
    logic                 o_inside_res;
    logic                 o_last;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [COORD_W-1:0]   i_cfg_data;

    // Shadow copy of the grid registers.
    logic [COORD_W-1:0] grid_origin [NUM_AXES];
    logic [COORD_W-1:0] grid_inv;
    logic [SIZE_W-1:0]  grid_size [NUM_AXES];

    t_stencil_node pending_nodes [$];
    t_stim_row     stim_rows [$];
    int            err_count    = 0;
    int            holds_asked  = 0;
    int            holds_served = 0;

    bspline_stencil_node_query #(
        .MAX_DIM(MAX_DIM)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_point_z    (i_point_z),
        .o_empty      (o_empty),
        .i_pop        (i_pop),
        .o_node_x     (o_node_x),
        .o_node_y     (o_node_y),
        .o_node_z     (o_node_z),
        .o_stencil_pos(o_stencil_pos),
        .o_inside_res (o_inside_res),
        .o_last       (o_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("bspline_stencil_node_query: mismatch");
        $finish;
    end

    task automatic report_mismatch(input string what);
        err_count++;
        $display("[%0t] %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [NODE_W-1:0] got,
                               input logic [NODE_W-1:0] want, input int pos);
        if (got !== want)
            report_mismatch($sformatf("%s = 'h%0h, want 'h%0h at stencil pos %0d",
                                      name, got, want, pos));
    endtask

    // Base cell on one axis: floor((p - origin) * inv) - 1, clamped to [-4, MAX_DIM].
    function automatic int stencil_base(input logic [COORD_W-1:0] p,
                                        input logic [COORD_W-1:0] org);
        longint          rel;
        longint          q;
        longint unsigned mag;
        longint unsigned prod;
        rel  = longint'($signed(p)) - longint'($signed(org));
        mag  = (rel < 0) ? -rel : rel;
        prod = mag * {32'd0, grid_inv};
        // A negative product floors away from zero whenever a fraction is left.
        if (rel < 0)
            q = -longint'(prod >> 32) - ((prod[31:0] != 32'd0) ? 1 : 0);
        else
            q = longint'(prod >> 32);
        q = q - 1;
        if (q < -4) q = -4;
        if (q > MAX_DIM) q = MAX_DIM;
        return int'(q);
    endfunction

    function automatic void expand_stencil(input int bx, input int by, input int bz);
        t_stencil_node node;
        int            x;
        int            y;
        int            z;
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                for (int k = 0; k < 4; k++) begin
                    x = bx + i;
                    y = by + j;
                    z = bz + k;
                    node.node_x  = x[NODE_W-1:0];
                    node.node_y  = y[NODE_W-1:0];
                    node.node_z  = z[NODE_W-1:0];
                    node.pos     = POS_W'(i * 16 + j * 4 + k);
                    node.in_grid = x >= 0 && x < int'(grid_size[0]) &&
                                   y >= 0 && y < int'(grid_size[1]) &&
                                   z >= 0 && z < int'(grid_size[2]);
                    node.last    = (node.pos == STENCIL_LAST);
                    pending_nodes.insert(pending_nodes.size(), node);
                end
            end
        end
    endfunction

    function automatic void add_row(input t_stim_row row);
        stim_rows.insert(stim_rows.size(), row);
    endfunction

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic t_stim_row point_row(input logic [COORD_W-1:0] x, y, z);
        t_stim_row row;
        row.kind  = ROW_POINT;
        row.idx   = '0;
        row.px    = x;
        row.py    = y;
        row.pz    = z;
        row.known = 1'b0;
        row.bx    = 0;
        row.by    = 0;
        row.bz    = 0;
        return row;
    endfunction

    function automatic t_stim_row known_row(input logic [COORD_W-1:0] x, y, z,
                                            input int bx, by, bz);
        t_stim_row row;
        row       = point_row(x, y, z);
        row.known = 1'b1;
        row.bx    = bx;
        row.by    = by;
        row.bz    = bz;
        return row;
    endfunction

    function automatic t_stim_row reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [COORD_W-1:0] data);
        t_stim_row row;
        row      = point_row(data, '0, '0);
        row.kind = ROW_REG;
        row.idx  = idx;
        return row;
    endfunction

    // Leaves i_push high on acceptance so that back-to-back words need no second drive.
    task automatic send_point(input logic [COORD_W-1:0] px, py, pz, input int gap);
        if (i_cfg_valid) i_cfg_valid <= 1'b0;
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_push    <= 1'b1;
        i_point_x <= px;
        i_point_y <= py;
        i_point_z <= pz;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
    endtask

    task automatic drain_results();
        if (i_push) i_push <= 1'b0;
        while (pending_nodes.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_ORIGIN_X: grid_origin[0] = data;
            CFG_ORIGIN_Y: grid_origin[1] = data;
            CFG_ORIGIN_Z: grid_origin[2] = data;
            CFG_INV_CELL: grid_inv       = data;
            CFG_SIZE_X:   grid_size[0]   = data[SIZE_W-1:0];
            CFG_SIZE_Y:   grid_size[1]   = data[SIZE_W-1:0];
            CFG_SIZE_Z:   grid_size[2]   = data[SIZE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic check_node();
        t_stencil_node want;
        if (pending_nodes.size() == 0) begin
            report_mismatch($sformatf("node word with nothing pending, stencil pos %0d",
                                      o_stencil_pos));
            return;
        end
        want = pending_nodes.pop_front();
        check_field("node_x", o_node_x, want.node_x, int'(want.pos));
        check_field("node_y", o_node_y, want.node_y, int'(want.pos));
        check_field("node_z", o_node_z, want.node_z, int'(want.pos));
        check_field("stencil_pos", NODE_W'(o_stencil_pos), NODE_W'(want.pos),
                    int'(want.pos));
        check_field("inside_res", NODE_W'(o_inside_res), NODE_W'(want.in_grid),
                    int'(want.pos));
        check_field("last", NODE_W'(o_last), NODE_W'(want.last), int'(want.pos));
    endtask

    initial begin : result_side
        int idle_left;
        int busy_left;
        int hold_left;
        idle_left = 0;
        busy_left = 0;
        hold_left = 0;
        i_pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && i_pop && !o_empty) check_node();
            if (holds_served != holds_asked) begin
                holds_served++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_pop <= 1'b0;
            end else if (busy_left > 0) begin
                busy_left--;
                i_pop <= 1'b1;
            end else if (idle_left > 0) begin
                idle_left--;
                i_pop <= 1'b0;
            end else begin
                i_pop <= 1'b1;
                if ($urandom_range(0, 19) == 0) busy_left = 100;
                else idle_left = draw_gap();
            end
        end
    end

    initial begin : point_side
        logic [COORD_W-1:0] pt [NUM_AXES];
        logic [COORD_W-1:0] word;
        longint             offs;
        int                 g;
        int                 sz;

        i_rst_n     <= 1'b0;
        i_push      <= 1'b0;
        i_point_x   <= '0;
        i_point_y   <= '0;
        i_point_z   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        for (int a = 0; a < NUM_AXES; a++) begin
            grid_origin[a] = '0;
            grid_size[a]   = SIZE_RST;
        end
        grid_inv = INV_CELL_RST;

        // Reset geometry: origin at zero, unit cells, 1024 nodes per axis.
        add_row(known_row(32'h0, 32'h0, 32'h0, -1, -1, -1));
        add_row(known_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, MAX_DIM, -4, -1));
        add_row(known_row(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                          -4, MAX_DIM, -2));
        add_row(known_row(32'h0001_0000, 32'hFFFF_0000, 32'h0000_FFFF, 0, -2, -1));
        add_row(known_row(32'h03FE_0000, 32'h0400_0000, 32'h0401_0000,
                          1021, 1023, 1024));
        add_row(known_row(32'h0402_0000, 32'h03FC_8000, 32'h0003_0000,
                          MAX_DIM, 1019, 2));
        // A zero reciprocal puts every axis at cell -1.
        add_row(reg_row(CFG_INV_CELL, 32'h0));
        add_row(known_row(32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF, -1, -1, -1));
        // Largest reciprocal against origins at the opposite extremes.
        add_row(reg_row(CFG_INV_CELL, 32'hFFFF_FFFF));
        add_row(reg_row(CFG_ORIGIN_X, 32'h8000_0000));
        add_row(reg_row(CFG_ORIGIN_Y, 32'h7FFF_FFFF));
        add_row(known_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, MAX_DIM, -4, -1));
        add_row(known_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h1, -1, -1, -1));
        // Zero nodes on x; the write to the unused index must leave everything alone.
        add_row(reg_row(CFG_ORIGIN_X, 32'h0));
        add_row(reg_row(CFG_ORIGIN_Y, 32'h0));
        add_row(reg_row(CFG_INV_CELL, 32'h0001_0000));
        add_row(reg_row(CFG_SIZE_X, 32'h0));
        add_row(reg_row(CFG_SIZE_Y, 32'h1));
        add_row(reg_row(CFG_SIZE_Z, 32'h7FF));
        add_row(reg_row(CFG_UNUSED, 32'hFFFF_FFFF));
        add_row(known_row(32'h0, 32'h0, 32'h0, -1, -1, -1));
        add_row(point_row(32'h0002_0000, 32'hFFFF_8000, 32'h03FF_0000));
        add_row(reg_row(CFG_SIZE_X, 32'd1024));
        add_row(reg_row(CFG_SIZE_Y, 32'd3));
        add_row(reg_row(CFG_SIZE_Z, 32'd1));
        add_row(known_row(32'h0001_0000, 32'h0001_0000, 32'h0000_8000, 0, 0, -1));
        // Shifted origin, half-unit cells, size words with junk above the size field.
        add_row(reg_row(CFG_ORIGIN_X, 32'hFFF6_0000));
        add_row(reg_row(CFG_ORIGIN_Y, 32'h0005_4000));
        add_row(reg_row(CFG_ORIGIN_Z, 32'h0000_8000));
        add_row(reg_row(CFG_INV_CELL, 32'h0002_0000));
        add_row(reg_row(CFG_SIZE_X, 32'hFFFF_F810));
        add_row(reg_row(CFG_SIZE_Y, 32'h0000_F808));
        add_row(reg_row(CFG_SIZE_Z, 32'h1234_5805));
        add_row(point_row(32'hFFF7_0000, 32'h0006_0000, 32'h0001_0000));
        add_row(point_row(32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
        add_row(point_row(32'h0002_8000, 32'h0005_0000, 32'h8000_0000));
        add_row(reg_row(CFG_INV_CELL, 32'h0000_8000));
        add_row(reg_row(CFG_SIZE_X, 32'd5));
        add_row(point_row(32'h0004_0000, 32'hFFFE_0000, 32'h0001_1234));
        add_row(point_row(32'hFFF6_0000, 32'h0005_4000, 32'h0000_8000));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[r]) begin
            if (stim_rows[r].kind == ROW_REG) begin
                drain_results();
                write_reg(stim_rows[r].idx, stim_rows[r].px);
            end else begin
                send_point(stim_rows[r].px, stim_rows[r].py, stim_rows[r].pz, draw_gap());
                if (stim_rows[r].known)
                    expand_stencil(stim_rows[r].bx, stim_rows[r].by, stim_rows[r].bz);
                else
                    expand_stencil(stencil_base(stim_rows[r].px, grid_origin[0]),
                                   stencil_base(stim_rows[r].py, grid_origin[1]),
                                   stencil_base(stim_rows[r].pz, grid_origin[2]));
            end
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            // New geometry only once every node of the previous phase has been popped.
            drain_results();
            for (int a = 0; a < NUM_AXES; a++) begin
                case ($urandom_range(0, 9))
                    6, 7:    word = $urandom;
                    8:       word = 32'h8000_0000;
                    9:       word = 32'h7FFF_FFFF;
                    default: word = 32'($urandom_range(0, 32'h0080_0000)) - 32'h0040_0000;
                endcase
                write_reg(ORIGIN_REG[a], word);
            end
            case ($urandom_range(0, 9))
                6:       word = 32'h0001_0000;
                7:       word = 32'h0;
                8:       word = 32'hFFFF_FFFF;
                9:       word = $urandom;
                default: word = $urandom_range(32'h4000, 32'h4_0000);
            endcase
            write_reg(CFG_INV_CELL, word);
            for (int a = 0; a < NUM_AXES; a++) begin
                case ($urandom_range(0, 9))
                    6:       sz = 1;
                    7:       sz = 1024;
                    8:       sz = 0;
                    9:       sz = $urandom_range(0, 2047);
                    default: sz = $urandom_range(1, 24);
                endcase
                word = ($urandom & 32'hFFFF_F800) | 32'(sz);
                write_reg(SIZE_REG[a], word);
            end
            if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, $urandom);
            // The result side holds off for a long stretch so the block fills and stalls.
            if (ph == 1) holds_asked++;

            for (int n = 0; n < PHASE_POINTS; n++) begin
                for (int a = 0; a < NUM_AXES; a++) begin
                    sz = int'(grid_size[a]);
                    case ($urandom_range(0, 9))
                        8: word = $urandom;
                        9: begin
                            case ($urandom_range(0, 3))
                                0:       word = 32'h8000_0000;
                                1:       word = 32'h7FFF_FFFF;
                                2:       word = 32'h0;
                                default: word = 32'hFFFF_FFFF;
                            endcase
                        end
                        default: begin
                            // Aim a few cells around the grid so the inside flags vary.
                            g = int'($urandom_range(0, sz + 9)) - 6;
                            if (grid_inv == 32'h0) begin
                                word = $urandom;
                            end else begin
                                offs = (longint'(g) * 65536 +
                                        longint'($urandom_range(0, 65535))) * 65536 /
                                       longint'(grid_inv);
                                word = grid_origin[a] + offs[31:0];
                            end
                        end
                    endcase
                    pt[a] = word;
                end
                send_point(pt[0], pt[1], pt[2], (ph == 3) ? 0 : draw_gap());
                expand_stencil(stencil_base(pt[0], grid_origin[0]),
                               stencil_base(pt[1], grid_origin[1]),
                               stencil_base(pt[2], grid_origin[2]));
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("bspline_stencil_node_query: match");
        else
            $display("bspline_stencil_node_query: mismatch");
        $finish;
    end

endmodule
